### hdl/gbc_pkg.sv
// Package for the button gesture classifier: widths, phase and gesture codes,
// register map and the configuration struct.
// No dependencies; used by gbc_core and button_gesture_classifier.
package gbc_pkg;

  // Timer and ADC widths.
  localparam int TICK_BITS = 16;
  localparam int ADC_BITS  = 10;

  // Compare widths wide enough for both a register and the value it is checked against.
  localparam int TCMP_BITS = (TICK_BITS > 16) ? TICK_BITS : 16;
  localparam int ACMP_BITS = (ADC_BITS > 10) ? ADC_BITS : 10;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_FIELD_BITS  = ADC_BITS + 2;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 5;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [2:0] {
    REG_ACTIVE_LOW  = 3'd0,
    REG_LONG_TICKS  = 3'd1,
    REG_WINDOW      = 3'd2,
    REG_DEBOUNCE    = 3'd3,
    REG_LEFT_THR    = 3'd4,
    REG_RIGHT_THR   = 3'd5,
    REG_REPORT_HELD = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HOLD   = 3'd1,
    PH_PAUSE  = 3'd2,
    PH_WINDOW = 3'd3,
    PH_WAIT   = 3'd4,
    PH_REPEAT = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    G_SINGLE = 3'd0,
    G_DOUBLE = 3'd1,
    G_LONG   = 3'd2,
    G_CONT   = 3'd3,
    G_TURN   = 3'd4
  } gesture_t;

  localparam logic [1:0] BTN_LEFT  = 2'd0;
  localparam logic [1:0] BTN_RIGHT = 2'd1;
  localparam logic [1:0] BTN_ENC   = 2'd2;

  // Configuration register set as seen by the classifier core.
  typedef struct packed {
    logic        active_low;
    logic [15:0] long_press_ticks;
    logic [15:0] window_ticks;
    logic [7:0]  debounce_ticks;
    logic [9:0]  left_threshold;
    logic [9:0]  right_threshold;
    logic        report_held;
  } cfg_t;

endpackage

### hdl/button_gesture_classifier.sv
// Top level of the button gesture classifier: stream ports, input and result
// registers, configuration registers. Depends on gbc_pkg and gbc_core.
//
//   Channel   Direction  Handshake               Payload
//   in_*      slave      in_tvalid / in_tready   tick: line, ladder level, encoder flag
//   out_*     master     out_tvalid / out_tready result: button, gesture
//   p*        APB slave  psel, penable, pready   seven configuration registers
//
// One tick is taken per clock while in_tready is high. A taken tick waits in the
// input register until it moves on; the edge that steps it also loads its result
// into the result register, which drives out_tvalid. The input register moves
// on when the result register is empty or being taken; a result held by out_tready
// low stalls the input register, and in_tready drops once that register is full.
// rst_n is synchronous and loads the register defaults and the idle phase.
module button_gesture_classifier (
  input  logic                                clk,
  input  logic                                rst_n,
  // Fields from bit 0: button_line, ladder_level, encoder_moved, zero pad.
  input  logic [gbc_pkg::IN_DATA_BITS-1:0]    in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0: which_button[1:0], gesture[4:2], zero pad.
  output logic [gbc_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gbc_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [gbc_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [gbc_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                pready
);
  import gbc_pkg::*;

  cfg_t                        cfg_r;
  logic                        wr_en;
  logic [2:0]                  reg_sel;

  logic                        s1_valid_r;
  logic [IN_FIELD_BITS-1:0]    s1_data_r;
  logic                        s1_adv;

  logic                        out_valid_r;
  logic [OUT_FIELD_BITS-1:0]   out_data_r;

  logic                        emit;
  logic [1:0]                  which_button;
  logic [2:0]                  gesture;

  // Configuration port: zero-wait APB, register i at byte address 4*i.
  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_low       <= 1'b0;
      cfg_r.long_press_ticks <= 16'd300;
      cfg_r.window_ticks     <= 16'd500;
      cfg_r.debounce_ticks   <= 8'd10;
      cfg_r.left_threshold   <= 10'd860;
      cfg_r.right_threshold  <= 10'd983;
      cfg_r.report_held      <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_ACTIVE_LOW:  cfg_r.active_low       <= pwdata[0];
        REG_LONG_TICKS:  cfg_r.long_press_ticks <= pwdata[15:0];
        REG_WINDOW:      cfg_r.window_ticks     <= pwdata[15:0];
        REG_DEBOUNCE:    cfg_r.debounce_ticks   <= pwdata[7:0];
        REG_LEFT_THR:    cfg_r.left_threshold   <= pwdata[9:0];
        REG_RIGHT_THR:   cfg_r.right_threshold  <= pwdata[9:0];
        REG_REPORT_HELD: cfg_r.report_held      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_ACTIVE_LOW:  prdata = CFG_DATA_BITS'(cfg_r.active_low);
      REG_LONG_TICKS:  prdata = CFG_DATA_BITS'(cfg_r.long_press_ticks);
      REG_WINDOW:      prdata = CFG_DATA_BITS'(cfg_r.window_ticks);
      REG_DEBOUNCE:    prdata = CFG_DATA_BITS'(cfg_r.debounce_ticks);
      REG_LEFT_THR:    prdata = CFG_DATA_BITS'(cfg_r.left_threshold);
      REG_RIGHT_THR:   prdata = CFG_DATA_BITS'(cfg_r.right_threshold);
      REG_REPORT_HELD: prdata = CFG_DATA_BITS'(cfg_r.report_held);
      default:         prdata = '0;
    endcase
  end

  // Input register: the held tick moves on when the result register has room.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata[IN_FIELD_BITS-1:0];
    end
  end

  gbc_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (s1_adv),
    .button_line   (s1_data_r[0]),
    .ladder_level  (s1_data_r[ADC_BITS:1]),
    .encoder_moved (s1_data_r[ADC_BITS+1]),
    .cfg           (cfg_r),
    .emit          (emit),
    .which_button  (which_button),
    .gesture       (gesture)
  );

  // Result register: loaded when a stepped tick yields a result, cleared
  // when the result transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_data_r <= {gesture, which_button};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_BITS'(out_data_r);

endmodule

### hdl/gbc_core.sv
// Gesture classifier core: phase, press timer, debounce count and the
// per-tick next-state and result logic. Depends on gbc_pkg.
module gbc_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic                         button_line,
  input  logic [gbc_pkg::ADC_BITS-1:0] ladder_level,
  input  logic                         encoder_moved,
  input  gbc_pkg::cfg_t                cfg,
  output logic                         emit,
  output logic [1:0]                   which_button,
  output logic [2:0]                   gesture
);
  import gbc_pkg::*;

  localparam logic [TICK_BITS-1:0] TMAX = {TICK_BITS{1'b1}};

  phase_t                 phase_r, phase_nxt;
  logic [TICK_BITS-1:0]   elapsed_r, elapsed_nxt, elapsed_inc;
  logic [7:0]             pause_r, pause_nxt, pause_dec;
  gesture_t               pend_r, pend_nxt;
  logic [1:0]             held_r, held_nxt;

  logic                   pressed;
  logic                   do_pause, do_after, do_window, do_end;
  logic [TCMP_BITS-1:0]   el_cmp, long_cmp, win_cmp;
  logic [ACMP_BITS-1:0]   lvl_cmp, left_cmp, right_cmp;
  logic [1:0]             btn_pick;

  assign pressed = button_line ^ cfg.active_low;

  // The press timer counts in every timed phase and saturates at the top.
  always_comb begin
    elapsed_inc = elapsed_r;
    if ((phase_r == PH_HOLD || phase_r == PH_PAUSE || phase_r == PH_WINDOW ||
         phase_r == PH_WAIT) && elapsed_r != TMAX) begin
      elapsed_inc = elapsed_r + 1'b1;
    end
  end

  assign el_cmp    = TCMP_BITS'(elapsed_inc);
  assign long_cmp  = TCMP_BITS'(cfg.long_press_ticks);
  assign win_cmp   = TCMP_BITS'(cfg.window_ticks);
  assign lvl_cmp   = ACMP_BITS'(ladder_level);
  assign left_cmp  = ACMP_BITS'(cfg.left_threshold);
  assign right_cmp = ACMP_BITS'(cfg.right_threshold);
  assign pause_dec = (pause_r != 8'd0) ? pause_r - 8'd1 : 8'd0;

  // Ladder decode: left threshold is checked first.
  always_comb begin
    if (lvl_cmp < left_cmp) begin
      btn_pick = BTN_LEFT;
    end else if (lvl_cmp < right_cmp) begin
      btn_pick = BTN_RIGHT;
    end else begin
      btn_pick = BTN_ENC;
    end
  end

  // Next state and result. A zero debounce lets one tick fall through the
  // pause, window and end judgments in sequence.
  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_inc;
    pause_nxt   = pause_r;
    pend_nxt    = pend_r;
    held_nxt    = held_r;
    emit        = 1'b0;
    gesture     = pend_r;
    do_pause    = 1'b0;
    do_after    = 1'b0;
    do_window   = 1'b0;
    do_end      = 1'b0;

    unique case (phase_r)
      PH_HOLD: begin
        // Release wins over the long limit on the same tick.
        if (!pressed) begin
          do_pause = 1'b1;
        end else if (el_cmp > long_cmp) begin
          pend_nxt = G_LONG;
          do_pause = 1'b1;
        end
      end
      PH_PAUSE: begin
        pause_nxt = pause_dec;
        if (pause_dec == 8'd0) begin
          do_after = 1'b1;
        end
      end
      PH_WINDOW: begin
        do_window = 1'b1;
      end
      PH_WAIT: begin
        do_end = 1'b1;
      end
      PH_REPEAT: begin
        if (!pressed) begin
          phase_nxt = PH_IDLE;
        end else begin
          emit    = 1'b1;
          gesture = encoder_moved ? G_TURN : G_CONT;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (pressed) begin
          held_nxt    = btn_pick;
          elapsed_nxt = '0;
          pause_nxt   = 8'd0;
          pend_nxt    = G_SINGLE;
          phase_nxt   = PH_HOLD;
        end
      end
    endcase

    // Start of the debounce pause.
    if (do_pause) begin
      phase_nxt = PH_PAUSE;
      pause_nxt = cfg.debounce_ticks;
      if (cfg.debounce_ticks == 8'd0) begin
        do_after = 1'b1;
      end
    end

    // End of the pause: a long press skips the double-press window.
    if (do_after) begin
      if (pend_nxt == G_LONG) begin
        do_end = 1'b1;
      end else begin
        do_window = 1'b1;
      end
    end

    // Double-press window.
    if (do_window) begin
      phase_nxt = PH_WINDOW;
      if (el_cmp < win_cmp) begin
        if (pressed) begin
          pend_nxt = G_DOUBLE;
          do_end   = 1'b1;
        end
      end else begin
        do_end = 1'b1;
      end
    end

    // Report on release; held long press repeats on turn or report_held.
    if (do_end) begin
      phase_nxt = PH_WAIT;
      if (!pressed) begin
        phase_nxt = PH_IDLE;
        emit      = 1'b1;
        gesture   = pend_nxt;
      end else if (pend_nxt == G_LONG && encoder_moved) begin
        phase_nxt = PH_REPEAT;
        emit      = 1'b1;
        gesture   = G_TURN;
      end else if (pend_nxt == G_LONG && cfg.report_held) begin
        phase_nxt = PH_REPEAT;
        emit      = 1'b1;
        gesture   = G_LONG;
      end
    end
  end

  assign which_button = held_r;

  // State registers advance once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      elapsed_r <= '0;
      pause_r   <= 8'd0;
      pend_r    <= G_SINGLE;
      held_r    <= BTN_LEFT;
    end else if (step) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      pause_r   <= pause_nxt;
      pend_r    <= pend_nxt;
      held_r    <= held_nxt;
    end
  end

endmodule
